// ----- rtl/smd_pkg.sv -----
// Shared widths, constants, exponent factor table and divider request and response types for the softmax block.
package smd_pkg;

    localparam int SCORE_W             = 16;
    localparam int GAIN_W              = 16;
    localparam int PROB_W              = 17;
    localparam int INDEX_W             = 6;
    localparam int EXP_W               = 17;
    localparam int SUM_W               = 23;
    localparam int ACC_W               = 32;
    localparam int ARG_W               = 32;
    localparam int EXP_BITS            = 20;
    localparam int EXP_STEP_W          = 5;
    localparam int NUM_W               = 33;
    localparam int QUOT_W              = 17;
    localparam int DEFAULT_MAX_ACTIONS = 64;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(256);
    localparam logic [SCORE_W-1:0] SCORE_MIN   = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam logic [ARG_W-1:0]   EXP_LIMIT   = ARG_W'(12 * 65536);
    localparam logic [ACC_W-1:0]   ACC_ONE     = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [EXP_W-1:0]   EXP_ONE     = EXP_W'(65536);
    localparam logic [SUM_W-1:0]   SUM_ONE     = SUM_W'(65536);

    // Factors exp(-2^(k-16)) in Q1.31, each the rounded square of the one before
    function automatic logic [EXP_BITS-1:0][ACC_W-1:0] exp_factor_table();
        logic [EXP_BITS-1:0][ACC_W-1:0] t;
        logic [63:0]                    f;
        logic [63:0]                    p;
        f = 64'd2147450880;
        for (int k = 0; k < EXP_BITS; k++) begin
            t[k] = f[ACC_W-1:0];
            p    = f * f + 64'h4000_0000;
            f    = {31'd0, p[63:31]};
        end
        return t;
    endfunction

    localparam logic [EXP_BITS-1:0][ACC_W-1:0] EXP_FACTOR = exp_factor_table();

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numerator;
        logic [SUM_W-1:0]  divisor;
    } smd_div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } smd_div_rsp_t;

endpackage

// ----- rtl/smd_score_if.sv -----
// Score channel: valid/ready handshake carrying one score and its end-of-set mark.
interface smd_score_if
    import smd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;

    modport source (output valid, output score, output last_score, input ready);
    modport sink   (input valid, input score, input last_score, output ready);
endinterface

// ----- rtl/smd_prob_if.sv -----
// Probability channel: valid/ready handshake carrying one probability, its index and end mark.
interface smd_prob_if
    import smd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [PROB_W-1:0]  probability;
    logic [INDEX_W-1:0] action_index;
    logic               last_result;

    modport source (output valid, output probability, output action_index, output last_result,
                    input ready);
    modport sink   (input valid, input probability, input action_index, input last_result,
                    output ready);
endinterface

// ----- rtl/softmax_distribution.sv -----
// Softmax with temperature: stores a set of scores, then emits normalised probabilities.
//
// Scores enter on the scores channel (valid/ready), one request per score, signed Q8.8;
// last_score closes the set, as does the MAX_ACTIONS-th score. While the set is loading,
// scores are taken back to back. Once the set closes, scores is held off until the final
// result of the set is loaded into the output register for the probs channel.
// Exponent pass: per stored score one memory read, one difference-times-gain product and
// 20 multiply steps of the Q1.31 exponent sequencer, then a write-back; the steps are
// skipped when the argument is at or past the cut-off, and a zero is written back.
// Normalise pass: per score one memory read, a bit-serial divide for the 17-bit quotient
// and a push into the output register; the next score is not read before that push.
// Probabilities are Q1.16 (65536 is one), indexed from 0, the final one marked last_result.
// A stall on probs holds the output register, and the normalise pass waits for it to free.
// inverse_temperature (cfg_we/cfg_wdata, unsigned Q8.8) is to be written only while idle;
// the user is bound to this, the block does not enforce it. Reset empties the set and sets
// the gain to 1.0; the score and exponent memories need no clearing, since only entries
// of the current set are read.
module softmax_distribution
    import smd_pkg::*;
#(
    parameter int MAX_ACTIONS = DEFAULT_MAX_ACTIONS
)
(
    input  logic              clk,
    input  logic              rst_n,
    smd_score_if.sink         scores,
    smd_prob_if.source        probs,
    input  logic              cfg_we,
    input  logic [GAIN_W-1:0] cfg_wdata
);

    localparam int IDX_W   = $clog2(MAX_ACTIONS);
    localparam int COUNT_W = IDX_W + 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_EXP_RD,
        S_EXP_MUL,
        S_EXP_RUN,
        S_EXP_WR,
        S_DIV_RD,
        S_DIV_START,
        S_DIV_WAIT,
        S_DIV_PUSH
    } state_t;

    state_t              state_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  n_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [SCORE_W-1:0]  max_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [ARG_W-1:0]    x_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [EXP_STEP_W-1:0] k_reg;
    logic                exp_zero_reg;
    logic                out_valid_reg;
    logic [PROB_W-1:0]   out_prob_reg;
    logic [IDX_W-1:0]    out_index_reg;
    logic                out_last_reg;

    logic [SCORE_W-1:0]  score_mem [MAX_ACTIONS];
    logic [EXP_W-1:0]    exp_mem   [MAX_ACTIONS];
    logic [SCORE_W-1:0]  score_rd_reg;
    logic [EXP_W-1:0]    exp_rd_reg;

    logic                score_accept;
    logic                set_close;
    logic                is_last;
    logic                out_free;
    logic                out_load;
    logic [SCORE_W:0]    diff_wide;
    logic [ARG_W-1:0]    x_next;
    logic [ACC_W-1:0]    factor;
    logic [2*ACC_W-1:0]  acc_prod;
    logic [2*ACC_W-1:0]  acc_round;
    logic [ACC_W-1:0]    acc_next;
    logic [ACC_W-1:0]    acc_out;
    logic [EXP_W-1:0]    exp_value;
    logic [EXP_BITS-1:0] x_low;
    logic                exp_we;
    smd_div_req_t        div_req;
    smd_div_rsp_t        div_rsp;

    // Handshake and set bookkeeping
    assign score_accept = scores.valid && scores.ready;
    assign scores.ready = (state_reg == S_LOAD);
    assign set_close    = scores.last_score || (count_reg == COUNT_W'(MAX_ACTIONS - 1));
    assign is_last      = ({1'b0, i_reg} + COUNT_W'(1)) == n_reg;
    assign out_free     = !out_valid_reg || probs.ready;
    assign out_load     = (state_reg == S_DIV_PUSH) && out_free;

    // Gain register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_wdata;
        end
    end

    // Argument: (max - score) * gain, never negative
    assign diff_wide = {max_reg[SCORE_W-1], max_reg} - {score_rd_reg[SCORE_W-1], score_rd_reg};
    assign x_next    = {{(ARG_W - SCORE_W){1'b0}}, diff_wide[SCORE_W-1:0]}
                     * {{(ARG_W - GAIN_W){1'b0}}, gain_reg};

    // One exponent step: multiply by the factor for bit k and round to Q1.31
    assign x_low     = x_reg[EXP_BITS-1:0];
    assign factor    = EXP_FACTOR[k_reg];
    assign acc_prod  = {{ACC_W{1'b0}}, acc_reg} * {{ACC_W{1'b0}}, factor};
    assign acc_round = acc_prod + (2*ACC_W)'(64'h4000_0000);
    assign acc_next  = acc_round[2*ACC_W-2:ACC_W-1];
    assign acc_out   = acc_reg + ACC_W'(32'h4000);
    assign exp_value = exp_zero_reg ? '0 : acc_out[ACC_W-1:ACC_W-EXP_W];
    assign exp_we    = (state_reg == S_EXP_WR);

    // Score memory: write on load, read by index
    always_ff @(posedge clk)
    begin
        if (score_accept)
        begin
            score_mem[count_reg[IDX_W-1:0]] <= scores.score;
        end
        score_rd_reg <= score_mem[i_reg];
    end

    // Exponent memory: written in the exponent pass, read in the normalise pass
    always_ff @(posedge clk)
    begin
        if (exp_we)
        begin
            exp_mem[i_reg] <= exp_value;
        end
        exp_rd_reg <= exp_mem[i_reg];
    end

    // Divider request: (e * 65536 + sum / 2) / sum
    assign div_req.start     = (state_reg == S_DIV_START);
    assign div_req.numerator = {exp_rd_reg, 16'd0} + {{(NUM_W - SUM_W + 1){1'b0}},
                                                      sum_reg[SUM_W-1:1]};
    assign div_req.divisor   = sum_reg;

    smd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequencer: load, exponent pass, normalise pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            max_reg       <= SCORE_MIN;
            sum_reg       <= '0;
            x_reg         <= '0;
            acc_reg       <= ACC_ONE;
            k_reg         <= '0;
            exp_zero_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_prob_reg  <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // Load a new result, or drop the one taken by the receiver
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (probs.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (score_accept)
                    begin
                        if (count_reg == '0 || $signed(scores.score) > $signed(max_reg))
                        begin
                            max_reg <= scores.score;
                        end
                        count_reg <= count_reg + COUNT_W'(1);
                        if (set_close)
                        begin
                            n_reg     <= count_reg + COUNT_W'(1);
                            i_reg     <= '0;
                            sum_reg   <= '0;
                            state_reg <= S_EXP_RD;
                        end
                    end
                end
                S_EXP_RD:
                begin
                    state_reg <= S_EXP_MUL;
                end
                S_EXP_MUL:
                begin
                    x_reg        <= x_next;
                    acc_reg      <= ACC_ONE;
                    k_reg        <= '0;
                    exp_zero_reg <= 1'b0;
                    state_reg    <= S_EXP_RUN;
                end
                S_EXP_RUN:
                begin
                    if (x_reg >= EXP_LIMIT)
                    begin
                        exp_zero_reg <= 1'b1;
                        state_reg    <= S_EXP_WR;
                    end
                    else
                    begin
                        if (x_low[k_reg])
                        begin
                            acc_reg <= acc_next;
                        end
                        k_reg <= k_reg + EXP_STEP_W'(1);
                        if (k_reg == EXP_STEP_W'(EXP_BITS - 1))
                        begin
                            state_reg <= S_EXP_WR;
                        end
                    end
                end
                S_EXP_WR:
                begin
                    sum_reg <= sum_reg + {{(SUM_W - EXP_W){1'b0}}, exp_value};
                    if (is_last)
                    begin
                        i_reg     <= '0;
                        state_reg <= S_DIV_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= S_EXP_RD;
                    end
                end
                S_DIV_RD:
                begin
                    state_reg <= S_DIV_START;
                end
                S_DIV_START:
                begin
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        state_reg <= S_DIV_PUSH;
                    end
                end
                S_DIV_PUSH:
                begin
                    if (out_free)
                    begin
                        out_prob_reg  <= div_rsp.quotient;
                        out_index_reg <= i_reg;
                        out_last_reg  <= is_last;
                        if (is_last)
                        begin
                            count_reg <= '0;
                            max_reg   <= SCORE_MIN;
                            sum_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + IDX_W'(1);
                            state_reg <= S_DIV_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    // Output channel
    assign probs.valid        = out_valid_reg;
    assign probs.probability  = out_prob_reg;
    assign probs.action_index = INDEX_W'(out_index_reg);
    assign probs.last_result  = out_last_reg;

    // A closing score starts the exponent pass on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (score_accept && set_close) |=> (state_reg == S_EXP_RD))
        else $error("closing score did not start the exponent pass");

    // The divider only reports back while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV_WAIT))
        else $error("divider finished outside the wait state");

    // The maximum score contributes one, so the sum is at least one before dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_START) |-> (sum_reg >= SUM_ONE))
        else $error("exponent sum below one at normalisation");

    // An exponent written back never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        exp_we |-> (exp_value <= EXP_ONE))
        else $error("exponent value above one");

    // No score is taken while results of the set are still being formed
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_PUSH && out_free && !is_last) |=> !scores.ready)
        else $error("scores accepted in the middle of the normalise pass");

endmodule

// ----- rtl/smd_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the normalisation pass.
module smd_divider
    import smd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  smd_div_req_t req,
    output smd_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUOT_W);
    localparam int LOW_W = NUM_W - QUOT_W;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SUM_W-1:0]  rem_reg;
    logic [SUM_W-1:0]  divisor_reg;
    logic [QUOT_W-1:0] num_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;
    logic              fits;
    logic              final_step;

    // Trial subtraction of the shifted remainder
    assign trial      = {rem_reg, num_reg[QUOT_W-1]};
    assign diff       = trial - {1'b0, divisor_reg};
    assign fits       = (trial >= {1'b0, divisor_reg});
    assign final_step = busy_reg && !req.start && (cnt_reg == CNT_W'(QUOT_W - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= final_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (final_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: high numerator bits seed the remainder, low bits shift in
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= {{(SUM_W - LOW_W){1'b0}}, req.numerator[NUM_W-1:QUOT_W]};
            num_reg     <= req.numerator[QUOT_W-1:0];
            divisor_reg <= req.divisor;
            quot_reg    <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            num_reg  <= {num_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for softmax_distribution: score sets in, probabilities checked.
module testbench
    import smd_pkg::*;
();

    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 12;
    localparam int SET_CAP     = DEFAULT_MAX_ACTIONS;
    localparam int SHOW_LIMIT  = 10;
    localparam int PHASE_ITEMS = 40;
    localparam int SETTLE      = 60;

    typedef struct packed {
        logic [PROB_W-1:0]  probability;
        logic [INDEX_W-1:0] action_index;
        logic               last_result;
    } prob_result_t;

    // Predicts the probabilities of each closed score set and checks them in order
    class softmax_board;
        logic signed [SCORE_W-1:0] held_scores [SET_CAP];
        logic signed [SCORE_W-1:0] top_score = SCORE_MIN;
        int                        held      = 0;
        logic [GAIN_W-1:0]         gain      = GAIN_RESET;
        prob_result_t              due_probs [$];
        int                        errors    = 0;

        // exp(-arg) for an unsigned Q16.16 argument, Q1.16 result
        function logic [EXP_W-1:0] neg_exp_q16(logic [63:0] arg);
            logic [63:0] acc;
            logic [63:0] factor;
            if (arg >= 64'(EXP_LIMIT))
                return '0;
            acc    = 64'(ACC_ONE);
            factor = 64'd2147450880;
            for (int k = 0; k < 20; k++)
            begin
                if (arg[k])
                    acc = (acc * factor + 64'h4000_0000) >> 31;
                factor = (factor * factor + 64'h4000_0000) >> 31;
            end
            return EXP_W'((acc + 64'h4000) >> 15);
        endfunction

        function void note_score(logic signed [SCORE_W-1:0] s, logic last);
            logic [EXP_W-1:0] weight [SET_CAP];
            logic [SUM_W-1:0] total;
            logic [63:0]      diff;
            prob_result_t     r;
            if (held == 0 || s > top_score)
                top_score = s;
            held_scores[held] = s;
            held++;
            if (!last && held < SET_CAP)
                return;
            // Exponent pass over the closed set
            total = '0;
            for (int i = 0; i < held; i++)
            begin
                diff      = 64'(int'(top_score) - int'(held_scores[i]));
                weight[i] = neg_exp_q16(diff * 64'(gain));
                total     = total + SUM_W'(weight[i]);
            end
            // Normalise with rounding
            for (int i = 0; i < held; i++)
            begin
                r.probability  = (total == '0) ? '0 :
                    PROB_W'((64'(weight[i]) * 64'd65536 + 64'(total / 2)) / 64'(total));
                r.action_index = INDEX_W'(i);
                r.last_result  = (i == held - 1);
                due_probs.push_back(r);
            end
            held      = 0;
            top_score = SCORE_MIN;
        endfunction

        function void check_probability(logic [PROB_W-1:0] p, logic [INDEX_W-1:0] idx,
                                        logic last);
            prob_result_t want;
            if (due_probs.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected probability %0d index %0d last %0b", p, idx, last);
                return;
            end
            want = due_probs.pop_front();
            if (want.probability !== p || want.action_index !== idx || want.last_result !== last)
            begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display({"mismatch: expected p %0d index %0d last %0b,",
                              " got p %0d index %0d last %0b"},
                             want.probability, want.action_index, want.last_result,
                             p, idx, last);
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [GAIN_W-1:0] cfg_wdata = '0;
    bit                steady    = 1'b0;
    int                cycles    = 0;
    softmax_board      board     = new;

    smd_score_if score_ch ();
    smd_prob_if  prob_ch ();

    softmax_distribution i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .scores    (score_ch),
        .probs     (prob_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        score_ch.valid      = 1'b0;
        score_ch.score      = '0;
        score_ch.last_score = 1'b0;
        prob_ch.ready       = 1'b0;
    end

    // Stall the probability side at random, except during the steady stretch
    always @(posedge clk)
        prob_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    // Check every accepted probability request
    always @(posedge clk)
        if (rst_n && prob_ch.valid && prob_ch.ready)
            board.check_probability(prob_ch.probability, prob_ch.action_index,
                                    prob_ch.last_result);

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one score request, with a random gap first, and hold it until taken
    task automatic send_score(input logic [SCORE_W-1:0] s, input logic last);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            score_ch.valid <= 1'b0;
            @(posedge clk);
        end
        score_ch.valid      <= 1'b1;
        score_ch.score      <= s;
        score_ch.last_score <= last;
        @(posedge clk);
        while (!score_ch.ready)
            @(posedge clk);
        board.note_score(s, last);
    endtask

    // Drop valid and wait until every predicted probability has arrived
    task automatic drain_sets();
        score_ch.valid <= 1'b0;
        while (board.due_probs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_gain(input logic [GAIN_W-1:0] g);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.gain = g;
        @(posedge clk);
    endtask

    // A set of random size and content; narrow sets get a spread that shrinks with gain
    task automatic play_random_set(input logic [GAIN_W-1:0] g, input bit full, output int n);
        int                 kind;
        int                 spread;
        bit                 wide;
        bit                 mark_end;
        logic [SCORE_W-1:0] base;
        logic [SCORE_W-1:0] s;
        kind = $urandom_range(0, 99);
        if (full || kind < 5)
            n = SET_CAP;
        else if (kind < 20)
            n = $urandom_range(9, 40);
        else
            n = $urandom_range(1, 8);
        mark_end = full ? 1'b0 : 1'($urandom_range(0, 1));
        spread   = 786432 / (int'(g) + 1) + 1;
        if (spread > 65535)
            spread = 65535;
        wide = ($urandom_range(0, 99) < 20);
        base = SCORE_W'($urandom());
        for (int i = 0; i < n; i++)
        begin
            s = wide ? SCORE_W'($urandom()) : base + SCORE_W'($urandom_range(0, spread));
            send_score(s, (i == n - 1) && (n < SET_CAP || mark_end));
        end
    endtask

    initial
    begin
        logic [GAIN_W-1:0] phase_gain [8];
        int                items;
        int                n;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets at the reset gain: single score, extremes, ties, exponent cut-off
        send_score(16'h0000, 1'b1);
        send_score(16'h7fff, 1'b0);
        send_score(16'h8000, 1'b1);
        send_score(16'h0100, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'hff00, 1'b1);
        send_score(16'h0005, 1'b0);
        send_score(16'h0005, 1'b1);
        send_score(16'h0c00, 1'b0);
        send_score(16'h0000, 1'b0);
        send_score(16'h0001, 1'b1);
        drain_sets();

        // Zero gain gives a uniform spread
        load_gain(16'h0000);
        send_score(SCORE_W'($urandom()), 1'b0);
        send_score(SCORE_W'($urandom()), 1'b0);
        send_score(SCORE_W'($urandom()), 1'b1);
        drain_sets();

        // Largest gain on small differences
        load_gain(16'hffff);
        send_score(16'h0000, 1'b0);
        send_score(16'h0001, 1'b0);
        send_score(16'h0002, 1'b1);
        send_score(16'h8000, 1'b0);
        send_score(16'h8001, 1'b1);
        drain_sets();

        // Smallest non-zero gain across the full score range
        load_gain(16'h0001);
        send_score(16'h8000, 1'b0);
        send_score(16'h7fff, 1'b0);
        send_score(16'h0000, 1'b1);
        drain_sets();

        // Random phases, one gain each; the first opens with a set closed by filling up
        phase_gain = '{GAIN_RESET, GAIN_W'($urandom()), 16'h0000, 16'hffff,
                       16'h0001, GAIN_W'($urandom()), 16'h1000, GAIN_W'($urandom())};
        for (int p = 0; p < 8; p++)
        begin
            load_gain(phase_gain[p]);
            steady = (p == 4);
            items  = 0;
            while (items < PHASE_ITEMS)
            begin
                play_random_set(phase_gain[p], (p == 0) && (items == 0), n);
                items += n;
            end
            drain_sets();
        end
        steady = 1'b0;

        board.errors += board.due_probs.size();
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/smd_pkg.sv
rtl/smd_score_if.sv
rtl/smd_prob_if.sv
rtl/smd_divider.sv
rtl/softmax_distribution.sv
dv/testbench.sv
